FILE: rtl/core/qrv_pkg.sv
// shared types and constants for the quaternion vector rotation pipeline
`timescale 1ns / 1ps

package qrv_pkg;

  // component width of the quaternion, vector and rotated vector
  localparam int unsigned COMP_W  = 16;
  // first Hamilton product: 16x16 terms and their three-term sums
  localparam int unsigned PROD1_W = 2 * COMP_W;
  localparam int unsigned T_W     = PROD1_W + 2;
  // second Hamilton product: 34x16 terms and their four-term sums
  localparam int unsigned PROD2_W = T_W + COMP_W;
  localparam int unsigned ACC_W   = PROD2_W + 2;
  // result scale is Q14 * Q14
  localparam int unsigned FRAC_W  = 28;
  localparam int unsigned SHR_W   = ACC_W - FRAC_W;

  localparam logic signed [ACC_W-1:0]  ROUND_HALF = ACC_W'(64'sd1 <<< (FRAC_W - 1));
  localparam logic signed [COMP_W-1:0] ROT_MAX    = 16'sh7fff;
  localparam logic signed [COMP_W-1:0] ROT_MIN    = 16'sh8000;

  typedef struct packed {
    logic signed [COMP_W-1:0] quat_w;
    logic signed [COMP_W-1:0] quat_x;
    logic signed [COMP_W-1:0] quat_y;
    logic signed [COMP_W-1:0] quat_z;
    logic signed [COMP_W-1:0] vec_x;
    logic signed [COMP_W-1:0] vec_y;
    logic signed [COMP_W-1:0] vec_z;
  } qrv_in_t;

  typedef struct packed {
    logic signed [COMP_W-1:0] rot_x;
    logic signed [COMP_W-1:0] rot_y;
    logic signed [COMP_W-1:0] rot_z;
    logic                     clipped;
  } qrv_out_t;

endpackage

FILE: rtl/core/quaternion_rotate_vector_unit.sv
// top level of the quaternion vector rotation pipeline
`timescale 1ns / 1ps

// Rotates a vector by a quaternion as r = q * (0,v) * conj(q), one word per clock
// while in_stall_o is low. The quaternion is signed Q1.14 and is not normalized,
// so a non-unit q scales the result by its squared norm. The work runs through
// five register stages: the 16x16 products of the first Hamilton product, their
// sums (t), the 34x16 products of the second Hamilton product, their sums plus
// the rounding offset, and finally the 28-bit shift with saturation into the
// output register. A new word can be accepted every cycle while the output is
// not stalled. Each stage holds its word only while the stage after it is full
// and held, so bubbles are squeezed out and a word can still enter while a
// finished result waits at the output. Rounding is to nearest with halves going
// toward positive infinity; clipped is set when any component saturated.
module quaternion_rotate_vector_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  qrv_pkg::qrv_in_t  in_word_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output qrv_pkg::qrv_out_t out_word_o
);

  localparam int unsigned CW  = qrv_pkg::COMP_W;
  localparam int unsigned P1W = qrv_pkg::PROD1_W;
  localparam int unsigned TW  = qrv_pkg::T_W;
  localparam int unsigned P2W = qrv_pkg::PROD2_W;
  localparam int unsigned AW  = qrv_pkg::ACC_W;
  localparam int unsigned SW  = qrv_pkg::SHR_W;

  // per-stage valid bits and load enables
  logic v1_q, v2_q, v3_q, v4_q, v5_q;
  logic en1, en2, en3, en4, en5;

  // a stage loads when it is empty or its content moves on
  assign en5 = !v5_q || !out_stall_i;
  assign en4 = !v4_q || en5;
  assign en3 = !v3_q || en4;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;

  assign in_stall_o  = !en1;
  assign out_valid_o = v5_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
      if (en5) v5_q <= v4_q;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 1: the twelve 16x16 products of q * (0,v)
  // ---------------------------------------------------------------------------
  logic signed [P1W-1:0] p_xx_q, p_yy_q, p_zz_q;   // dot product terms
  logic signed [P1W-1:0] p_yz_q, p_zy_q;           // cross x terms
  logic signed [P1W-1:0] p_zx_q, p_xz_q;           // cross y terms
  logic signed [P1W-1:0] p_xy_q, p_yx_q;           // cross z terms
  logic signed [P1W-1:0] p_wx_q, p_wy_q, p_wz_q;   // scalar times vector
  logic signed [CW-1:0]  q1w_q, q1x_q, q1y_q, q1z_q;

  always_ff @(posedge clk_i) begin
    if (en1) begin
      p_xx_q <= in_word_i.quat_x * in_word_i.vec_x;
      p_yy_q <= in_word_i.quat_y * in_word_i.vec_y;
      p_zz_q <= in_word_i.quat_z * in_word_i.vec_z;
      p_yz_q <= in_word_i.quat_y * in_word_i.vec_z;
      p_zy_q <= in_word_i.quat_z * in_word_i.vec_y;
      p_zx_q <= in_word_i.quat_z * in_word_i.vec_x;
      p_xz_q <= in_word_i.quat_x * in_word_i.vec_z;
      p_xy_q <= in_word_i.quat_x * in_word_i.vec_y;
      p_yx_q <= in_word_i.quat_y * in_word_i.vec_x;
      p_wx_q <= in_word_i.quat_w * in_word_i.vec_x;
      p_wy_q <= in_word_i.quat_w * in_word_i.vec_y;
      p_wz_q <= in_word_i.quat_w * in_word_i.vec_z;
      q1w_q  <= in_word_i.quat_w;
      q1x_q  <= in_word_i.quat_x;
      q1y_q  <= in_word_i.quat_y;
      q1z_q  <= in_word_i.quat_z;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 2: t = q * (0,v), scalar is minus the dot product
  // ---------------------------------------------------------------------------
  logic signed [TW-1:0] t0_d, t1_d, t2_d, t3_d;
  logic signed [TW-1:0] t0_q, t1_q, t2_q, t3_q;
  logic signed [CW-1:0] q2w_q, q2x_q, q2y_q, q2z_q;

  always_comb begin
    t0_d = -(TW'(p_xx_q) + TW'(p_yy_q) + TW'(p_zz_q));
    t1_d = TW'(p_wx_q) + TW'(p_yz_q) - TW'(p_zy_q);
    t2_d = TW'(p_wy_q) + TW'(p_zx_q) - TW'(p_xz_q);
    t3_d = TW'(p_wz_q) + TW'(p_xy_q) - TW'(p_yx_q);
  end

  always_ff @(posedge clk_i) begin
    if (en2) begin
      t0_q  <= t0_d;
      t1_q  <= t1_d;
      t2_q  <= t2_d;
      t3_q  <= t3_d;
      q2w_q <= q1w_q;
      q2x_q <= q1x_q;
      q2y_q <= q1y_q;
      q2z_q <= q1z_q;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 3: products of t * conj(q); the conjugate signs are folded into
  // the sums of stage 4 so -32768 never needs negating here
  // ---------------------------------------------------------------------------
  logic signed [P2W-1:0] m_x0_q, m_w1_q, m_z2_q, m_y3_q;   // for rot x
  logic signed [P2W-1:0] m_y0_q, m_w2_q, m_x3_q, m_z1_q;   // for rot y
  logic signed [P2W-1:0] m_z0_q, m_w3_q, m_y1_q, m_x2_q;   // for rot z

  always_ff @(posedge clk_i) begin
    if (en3) begin
      m_x0_q <= q2x_q * t0_q;
      m_w1_q <= q2w_q * t1_q;
      m_z2_q <= q2z_q * t2_q;
      m_y3_q <= q2y_q * t3_q;
      m_y0_q <= q2y_q * t0_q;
      m_w2_q <= q2w_q * t2_q;
      m_x3_q <= q2x_q * t3_q;
      m_z1_q <= q2z_q * t1_q;
      m_z0_q <= q2z_q * t0_q;
      m_w3_q <= q2w_q * t3_q;
      m_y1_q <= q2y_q * t1_q;
      m_x2_q <= q2x_q * t2_q;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 4: vector part of r in Q28, with the half-lsb rounding offset added
  // ---------------------------------------------------------------------------
  logic signed [AW-1:0] rx_d, ry_d, rz_d;
  logic signed [AW-1:0] rx_q, ry_q, rz_q;

  always_comb begin
    rx_d = AW'(m_w1_q) - AW'(m_x0_q) - AW'(m_z2_q) + AW'(m_y3_q) + qrv_pkg::ROUND_HALF;
    ry_d = AW'(m_w2_q) - AW'(m_y0_q) - AW'(m_x3_q) + AW'(m_z1_q) + qrv_pkg::ROUND_HALF;
    rz_d = AW'(m_w3_q) - AW'(m_z0_q) - AW'(m_y1_q) + AW'(m_x2_q) + qrv_pkg::ROUND_HALF;
  end

  always_ff @(posedge clk_i) begin
    if (en4) begin
      rx_q <= rx_d;
      ry_q <= ry_d;
      rz_q <= rz_d;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 5: floor shift by 28, saturate to 16 bits, gather the clip flag
  // ---------------------------------------------------------------------------
  // returns {clip, value}
  function automatic logic [CW:0] shift_sat(input logic signed [AW-1:0] acc);
    logic signed [SW-1:0] sh;
    logic [CW:0]          res;
    sh = acc[AW-1:qrv_pkg::FRAC_W];
    if (sh > SW'(qrv_pkg::ROT_MAX)) begin
      res = {1'b1, qrv_pkg::ROT_MAX};
    end else if (sh < SW'(qrv_pkg::ROT_MIN)) begin
      res = {1'b1, qrv_pkg::ROT_MIN};
    end else begin
      res = {1'b0, sh[CW-1:0]};
    end
    return res;
  endfunction

  logic [CW:0]        sx, sy, sz;
  qrv_pkg::qrv_out_t  out_d;
  qrv_pkg::qrv_out_t  out_q;

  always_comb begin
    sx            = shift_sat(rx_q);
    sy            = shift_sat(ry_q);
    sz            = shift_sat(rz_q);
    out_d.rot_x   = sx[CW-1:0];
    out_d.rot_y   = sy[CW-1:0];
    out_d.rot_z   = sz[CW-1:0];
    out_d.clipped = sx[CW] | sy[CW] | sz[CW];
  end

  always_ff @(posedge clk_i) begin
    if (en5) begin
      out_q <= out_d;
    end
  end

  assign out_word_o = out_q;

endmodule

FILE: tb/qrv_rotation_checker.sv
// scoreboard for the quaternion vector rotation unit: predicts each rotation and compares
`timescale 1ns / 1ps

module qrv_rotation_checker (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_stall_i,
  input  qrv_pkg::qrv_in_t  in_word_i,
  input  logic              out_valid_i,
  input  logic              out_stall_i,
  input  qrv_pkg::qrv_out_t out_word_i,
  output int                err_count_o,
  output int                pending_o,
  output int                checked_o,
  output int                clipped_o
);

  localparam longint ROUND_Q28 = 64'sd1 <<< (qrv_pkg::FRAC_W - 1);

  qrv_pkg::qrv_out_t rotation_q[$];

  // round to nearest (halves up) and saturate, returns {clip, value}
  function automatic logic [qrv_pkg::COMP_W:0] round_saturate(input longint acc);
    longint s;
    s = (acc + ROUND_Q28) >>> qrv_pkg::FRAC_W;
    if (s > 32767) return {1'b1, qrv_pkg::ROT_MAX};
    if (s < -32768) return {1'b1, qrv_pkg::ROT_MIN};
    return {1'b0, s[qrv_pkg::COMP_W-1:0]};
  endfunction

  // r = q * (0,v) * conj(q) at full precision
  function automatic qrv_pkg::qrv_out_t rotate_expected(input qrv_pkg::qrv_in_t w);
    longint qw, qx, qy, qz, vx, vy, vz;
    longint jx, jy, jz;
    longint tw, tx, ty, tz;
    longint rx, ry, rz;
    logic [qrv_pkg::COMP_W:0] sx, sy, sz;
    qrv_pkg::qrv_out_t res;
    qw = longint'($signed(w.quat_w));
    qx = longint'($signed(w.quat_x));
    qy = longint'($signed(w.quat_y));
    qz = longint'($signed(w.quat_z));
    vx = longint'($signed(w.vec_x));
    vy = longint'($signed(w.vec_y));
    vz = longint'($signed(w.vec_z));
    tw = -(qx * vx + qy * vy + qz * vz);
    tx = vx * qw + (qy * vz - vy * qz);
    ty = vy * qw + (qz * vx - vz * qx);
    tz = vz * qw + (qx * vy - vx * qy);
    jx = -qx;
    jy = -qy;
    jz = -qz;
    rx = jx * tw + tx * qw + (ty * jz - jy * tz);
    ry = jy * tw + ty * qw + (tz * jx - jz * tx);
    rz = jz * tw + tz * qw + (tx * jy - jx * ty);
    sx = round_saturate(rx);
    sy = round_saturate(ry);
    sz = round_saturate(rz);
    res.rot_x   = sx[qrv_pkg::COMP_W-1:0];
    res.rot_y   = sy[qrv_pkg::COMP_W-1:0];
    res.rot_z   = sz[qrv_pkg::COMP_W-1:0];
    res.clipped = sx[qrv_pkg::COMP_W] | sy[qrv_pkg::COMP_W] | sz[qrv_pkg::COMP_W];
    return res;
  endfunction

  initial begin
    err_count_o = 0;
    pending_o   = 0;
    checked_o   = 0;
    clipped_o   = 0;
  end

  always @(posedge clk_i) begin
    qrv_pkg::qrv_out_t exp_word;
    if (rst_ni) begin
      // compare before queuing, so a stray result never meets its own prediction
      if (out_valid_i && !out_stall_i) begin
        if (rotation_q.size() == 0) begin
          $display("%0t: unexpected result x=%0d y=%0d z=%0d clipped=%0b", $time,
                   out_word_i.rot_x, out_word_i.rot_y, out_word_i.rot_z, out_word_i.clipped);
          err_count_o++;
        end else begin
          exp_word = rotation_q.pop_front();
          checked_o++;
          if (out_word_i.clipped) clipped_o++;
          if (out_word_i.rot_x !== exp_word.rot_x) begin
            $display("%0t: rot_x expected %0d actual %0d", $time, exp_word.rot_x,
                     out_word_i.rot_x);
            err_count_o++;
          end
          if (out_word_i.rot_y !== exp_word.rot_y) begin
            $display("%0t: rot_y expected %0d actual %0d", $time, exp_word.rot_y,
                     out_word_i.rot_y);
            err_count_o++;
          end
          if (out_word_i.rot_z !== exp_word.rot_z) begin
            $display("%0t: rot_z expected %0d actual %0d", $time, exp_word.rot_z,
                     out_word_i.rot_z);
            err_count_o++;
          end
          if (out_word_i.clipped !== exp_word.clipped) begin
            $display("%0t: clipped expected %0b actual %0b", $time, exp_word.clipped,
                     out_word_i.clipped);
            err_count_o++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) rotation_q.push_back(rotate_expected(in_word_i));
      pending_o = rotation_q.size();
    end
  end

endmodule

FILE: tb/quaternion_rotate_vector_unit_tb.sv
// testbench top for the quaternion vector rotation unit: stimulus, flow control and verdict
`timescale 1ns / 1ps

module quaternion_rotate_vector_unit_tb;

  localparam int RANDOM_WORDS   = 1700;
  // last stretch of the run goes without any idling on either side
  localparam int QUIET_TAIL     = 250;
  // the long receiver hold-off starts once this many words went in
  localparam int HOLD_AT        = 320;
  localparam int HOLD_CYCLES    = 80;
  // no handshake on either channel for this long means the block is stuck
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 12;

  logic              clk_i     = 1'b0;
  logic              rst_ni    = 1'b0;
  logic              in_valid  = 1'b0;
  logic              in_stall;
  qrv_pkg::qrv_in_t  in_word   = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  qrv_pkg::qrv_out_t out_word;

  int err_count;
  int pending;
  int checked;
  int clipped_seen;

  int words_sent  = 0;
  int total_words = 0;
  int idle_cycles = 0;
  bit quiet       = 1'b0;
  bit long_hold   = 1'b0;
  bit hold_done   = 1'b0;

  always #4 clk_i = ~clk_i;

  quaternion_rotate_vector_unit DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_word_i   (in_word),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_word_o  (out_word)
  );

  qrv_rotation_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .in_word_i   (in_word),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .out_word_i  (out_word),
    .err_count_o (err_count),
    .pending_o   (pending),
    .checked_o   (checked),
    .clipped_o   (clipped_seen)
  );

  // build one input word from plain integers (truncated to 16 bits)
  function automatic qrv_pkg::qrv_in_t mk_word(input int w, input int x, input int y,
                                               input int z, input int vx, input int vy,
                                               input int vz);
    qrv_pkg::qrv_in_t r;
    r.quat_w = w[15:0];
    r.quat_x = x[15:0];
    r.quat_y = y[15:0];
    r.quat_z = z[15:0];
    r.vec_x  = vx[15:0];
    r.vec_y  = vy[15:0];
    r.vec_z  = vz[15:0];
    return r;
  endfunction

  // a component drawn from the corners of the 16-bit range or anywhere
  function automatic int corner_value();
    case ($urandom_range(0, 5))
      0:       return -32768;
      1:       return -1;
      2:       return 0;
      3:       return 1;
      4:       return 32767;
      default: return int'($urandom_range(0, 65535));
    endcase
  endfunction

  // random word: full range, near-unit rotation, small quaternion, or corner values
  function automatic qrv_pkg::qrv_in_t random_word();
    real a, b, c, d, n;
    int kind;
    kind = $urandom_range(0, 9);
    if (kind < 3) begin
      return mk_word($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    end else if (kind < 7) begin
      // unit quaternion in Q1.14 from a random direction in 4-space
      a = real'(int'($urandom_range(0, 2000)) - 1000);
      b = real'(int'($urandom_range(0, 2000)) - 1000);
      c = real'(int'($urandom_range(0, 2000)) - 1000);
      d = real'(int'($urandom_range(0, 2000)) - 1000);
      n = $sqrt(a * a + b * b + c * c + d * d);
      if (n < 1.0) return mk_word(16384, 0, 0, 0, $urandom, $urandom, $urandom);
      return mk_word($rtoi(a / n * 16384.0), $rtoi(b / n * 16384.0),
                     $rtoi(c / n * 16384.0), $rtoi(d / n * 16384.0),
                     $urandom, $urandom, $urandom);
    end else if (kind < 9) begin
      return mk_word(int'($urandom_range(0, 1023)) - 512, int'($urandom_range(0, 1023)) - 512,
                     int'($urandom_range(0, 1023)) - 512, int'($urandom_range(0, 1023)) - 512,
                     $urandom, $urandom, $urandom);
    end
    return mk_word(corner_value(), corner_value(), corner_value(), corner_value(),
                   corner_value(), corner_value(), corner_value());
  endfunction

  // offer one word, maybe after an idle burst, and hold it until accepted
  task automatic push_word(input qrv_pkg::qrv_in_t w);
    if (!quiet && !long_hold && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk_i);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    words_sent++;
    @(negedge clk_i);
  endtask

  // receiver side: random stall bursts, one long hold-off, none in the tail
  initial begin
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!hold_done && words_sent >= HOLD_AT) begin
        // long hold-off while the sender keeps pushing, so the pipe fills up
        long_hold = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        out_stall <= 1'b0;
        long_hold = 1'b0;
        hold_done = 1'b1;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 10)) @(negedge clk_i);
        out_stall <= 1'b0;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // watchdog: cycles with no handshake on either channel
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: watchdog expired with %0d results outstanding", $time, pending);
        $display("quaternion_rotate_vector_unit_tb: errors");
        $finish;
      end
    end
  end

  // stimulus and verdict
  initial begin
    qrv_pkg::qrv_in_t directed[$];
    int n;

    // directed words: degenerate, identity, axis turns, rounding halves, saturation edges
    directed.push_back(mk_word(0, 0, 0, 0, 1234, -5678, 32767));            // zero quaternion
    directed.push_back(mk_word(16384, 0, 0, 0, 100, -200, 300));            // identity
    directed.push_back(mk_word(16384, 0, 0, 0, 32767, -32768, 32767));      // identity, extremes
    directed.push_back(mk_word(11585, 0, 0, 11585, 1000, 0, 0));            // quarter turn on z
    directed.push_back(mk_word(0, 16384, 0, 0, 1, 2, 3));                   // half turn on x
    directed.push_back(mk_word(0, 0, 16384, 0, -7, 8, -9));                 // half turn on y
    directed.push_back(mk_word(8192, 0, 0, 0, 2, -2, -6));                  // exact halves
    directed.push_back(mk_word(8192, 0, 0, 0, 6, -1, 1));                   // halves and quarters
    directed.push_back(mk_word(-32768, 0, 0, 0, 8191, 8192, -8192));        // scale 4, clip edge
    directed.push_back(mk_word(-32768, 0, 0, 0, -8193, 0, 1));              // negative clip edge
    directed.push_back(mk_word(-32768, -32768, -32768, -32768, 32767, 32767, 32767));
    directed.push_back(mk_word(32767, 32767, 32767, 32767, -32768, -32768, -32768));
    directed.push_back(mk_word(32767, -32768, 32767, -32768, -32768, 32767, -32768));
    directed.push_back(mk_word(-32768, -32768, -32768, -32768, 0, 0, 0));   // zero vector
    directed.push_back(mk_word(-1, -1, -1, -1, -1, -1, -1));
    directed.push_back(mk_word(1, 1, 1, 1, 32767, 32767, 32767));           // tiny quaternion
    directed.push_back(mk_word(16384, 16384, 16384, 16384, 10000, -10000, 5000)); // norm 2
    directed.push_back(mk_word(32'h5555, 32'haaaa, 32'h5555, 32'haaaa,
                               32'haaaa, 32'h5555, 32'haaaa));
    directed.push_back(mk_word(32'haaaa, 32'h5555, 32'haaaa, 32'h5555,
                               32'h5555, 32'haaaa, 32'h5555));
    directed.push_back(mk_word(0, 0, 0, 16384, -32768, -32768, -32768));    // z half turn, clip
    total_words = directed.size() + RANDOM_WORDS;

    // reset once, released on a falling edge
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (directed[i]) push_word(directed[i]);
    for (n = 0; n < RANDOM_WORDS; n++) begin
      if (words_sent >= total_words - QUIET_TAIL) quiet = 1'b1;
      push_word(random_word());
    end
    in_valid <= 1'b0;

    // drain: everything predicted must come out, then a few more cycles
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("covered %0d words (%0d directed, long output hold-off of %0d cycles)",
             words_sent, directed.size(), HOLD_CYCLES);
    $display("checked %0d rotations, %0d of them saturated", checked, clipped_seen);
    if (err_count == 0 && pending == 0) begin
      $display("quaternion_rotate_vector_unit_tb: clean");
    end else begin
      $display("quaternion_rotate_vector_unit_tb: errors");
    end
    $finish;
  end

endmodule
